@@ sv/wfs_pkg.sv @@
`default_nettype none

package wfs_pkg;

    // Configuration port geometry.
    localparam int APB_DW  = 32;
    localparam int PADDR_W = 3;
    localparam int IDX_W   = 1;

    // Register map: the register index sits above the byte offset.
    localparam logic [IDX_W-1:0] REG_WINDOW_SIZE = 1'b0;

    // Window size register.
    localparam int CFG_W = 7;
    localparam logic [CFG_W-1:0] WINDOW_SIZE_RESET = 7'd4;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic scan;
        logic finish;
        logic load_out;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_scan;
        logic emit;
        logic scan_busy;
        logic out_free;
    } t_dp_status;

endpackage

`default_nettype wire

@@ sv/wfs_if.sv @@
`default_nettype none

// Request channel carrying one k-gram hash.
interface wfs_item_if #(
    parameter int HASH_BITS = 31
) ();
    logic                 valid;
    logic                 ready;
    logic [HASH_BITS-1:0] hash_value;
    logic                 last_of_document;

    modport source (output valid, output hash_value, output last_of_document, input ready);
    modport sink   (input valid, input hash_value, input last_of_document, output ready);
endinterface

// Request channel carrying one selected fingerprint.
interface wfs_fp_if #(
    parameter int HASH_BITS = 31
) ();
    logic                 valid;
    logic                 ready;
    logic [HASH_BITS-1:0] fingerprint;

    modport source (output valid, output fingerprint, input ready);
    modport sink   (input valid, input fingerprint, output ready);
endinterface

`default_nettype wire

@@ sv/wfs_ctrl.sv @@
`default_nettype none

module wfs_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire wfs_pkg::t_dp_status i_status,
    output wfs_pkg::t_dp_cmd         o_cmd
);

    wfs_pkg::t_state r_state;
    wfs_pkg::t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wfs_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state: a rescan runs until its last compare, then the result waits for the output.
    always_comb begin
        n_state = r_state;
        case (r_state)
            wfs_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    if (i_status.need_scan) begin
                        n_state = wfs_pkg::ST_SCAN;
                    end else if (i_status.emit) begin
                        n_state = wfs_pkg::ST_EMIT;
                    end
                end
            end
            wfs_pkg::ST_SCAN: begin
                if (!i_status.scan_busy) begin
                    n_state = wfs_pkg::ST_EMIT;
                end
            end
            wfs_pkg::ST_EMIT: begin
                if (i_status.out_free) begin
                    n_state = wfs_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = wfs_pkg::ST_IDLE;
            end
        endcase
    end

    // Commands to the datapath.
    always_comb begin
        o_in_ready     = 1'b0;
        o_cmd          = '0;
        case (r_state)
            wfs_pkg::ST_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            wfs_pkg::ST_SCAN: begin
                o_cmd.scan   = 1'b1;
                o_cmd.finish = !i_status.scan_busy;
            end
            wfs_pkg::ST_EMIT: begin
                o_cmd.load_out = i_status.out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ sv/wfs_datapath.sv @@
`default_nettype none

module wfs_datapath #(
    parameter int WINDOW_MAX = 64,
    parameter int HASH_BITS  = 31
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire wfs_pkg::t_dp_cmd            i_cmd,
    output wfs_pkg::t_dp_status              o_status,
    input  wire logic [HASH_BITS-1:0]        i_hash_value,
    input  wire logic                        i_last_of_document,
    input  wire logic [wfs_pkg::CFG_W-1:0]   i_window_size,
    input  wire logic                        i_out_ready,
    output logic                             o_out_valid,
    output logic [HASH_BITS-1:0]             o_fingerprint
);

    localparam int PTR_W = $clog2(WINDOW_MAX);
    localparam int CNT_W = $clog2(WINDOW_MAX + 1);
    localparam int CW    = (CNT_W > wfs_pkg::CFG_W) ? CNT_W : wfs_pkg::CFG_W;

    // Window store: one write port, one registered read port.
    logic [HASH_BITS-1:0] r_mem [WINDOW_MAX];

    logic [PTR_W-1:0]     r_wp;
    logic [CNT_W-1:0]     r_seen;
    logic [HASH_BITS-1:0] r_min;
    logic [CNT_W-1:0]     r_age;
    logic                 r_last;
    logic [CNT_W-1:0]     r_iss_age;
    logic                 r_cmp_vld;
    logic                 r_out_vld;

    logic [PTR_W-1:0]     r_rd_ptr;
    logic [HASH_BITS-1:0] r_rd_data;
    logic [CNT_W-1:0]     r_cmp_age;
    logic [HASH_BITS-1:0] r_best;
    logic [CNT_W-1:0]     r_best_age;
    logic [HASH_BITS-1:0] r_res;
    logic [HASH_BITS-1:0] r_out_data;

    logic [CW-1:0]        ws_ext;
    logic [CNT_W-1:0]     ws;
    logic                 full;
    logic [CNT_W-1:0]     seen_inc;
    logic [CNT_W:0]       age1;
    logic                 fill_take;
    logic                 fill_emit;
    logic                 need_scan;
    logic                 cmp_emit;
    logic                 issue;
    logic [PTR_W-1:0]     wp_inc;
    logic [PTR_W-1:0]     first_rd;
    logic [PTR_W-1:0]     rd_dec;

    // Effective window size: zero counts as one, and it never exceeds the store.
    always_comb begin
        ws_ext = CW'(i_window_size);
        if (ws_ext == '0) begin
            ws_ext = CW'(1);
        end else if (ws_ext > CW'(WINDOW_MAX)) begin
            ws_ext = CW'(WINDOW_MAX);
        end
        ws = ws_ext[CNT_W-1:0];
    end

    // Per-item decision for the hash on the input channel.
    always_comb begin
        full      = (r_seen >= ws);
        seen_inc  = r_seen + CNT_W'(1);
        age1      = {1'b0, r_age} + (CNT_W + 1)'(1);
        fill_take = (r_seen == '0) || (i_hash_value <= r_min);
        fill_emit = (seen_inc == ws) || i_last_of_document;
        need_scan = full && (age1 >= {1'b0, ws});
        cmp_emit  = full && !need_scan && (i_hash_value < r_min);
        issue     = (r_iss_age < ws);
    end

    // Ring pointer arithmetic for a store depth that need not be a power of two.
    always_comb begin
        wp_inc   = (r_wp == PTR_W'(WINDOW_MAX - 1)) ? '0 : r_wp + PTR_W'(1);
        first_rd = (r_wp == '0) ? PTR_W'(WINDOW_MAX - 1) : r_wp - PTR_W'(1);
        rd_dec   = (r_rd_ptr == '0) ? PTR_W'(WINDOW_MAX - 1) : r_rd_ptr - PTR_W'(1);
    end

    // Status toward the controller.
    always_comb begin
        o_status.need_scan = need_scan;
        o_status.emit      = full ? cmp_emit : fill_emit;
        o_status.scan_busy = issue || r_cmp_vld;
        o_status.out_free  = !r_out_vld || i_out_ready;
    end

    // Document state, scan sequencing and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp      <= '0;
            r_seen    <= '0;
            r_min     <= '1;
            r_age     <= '0;
            r_last    <= 1'b0;
            r_iss_age <= '0;
            r_cmp_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cmd.accept) begin
                r_wp   <= wp_inc;
                r_last <= i_last_of_document;
                if (!full) begin
                    r_seen <= seen_inc;
                    if (fill_take) begin
                        r_min <= i_hash_value;
                        r_age <= '0;
                    end else if (r_age < CNT_W'(WINDOW_MAX)) begin
                        r_age <= r_age + CNT_W'(1);
                    end
                end else if (need_scan) begin
                    r_iss_age <= CNT_W'(1);
                    r_cmp_vld <= 1'b0;
                end else if (i_hash_value < r_min) begin
                    r_min <= i_hash_value;
                    r_age <= '0;
                end else begin
                    r_age <= age1[CNT_W-1:0];
                end
                // End of document without a rescan clears at once.
                if (i_last_of_document && !need_scan) begin
                    r_wp   <= '0;
                    r_seen <= '0;
                    r_min  <= '1;
                    r_age  <= '0;
                end
            end
            if (i_cmd.scan) begin
                r_cmp_vld <= issue;
                if (issue) begin
                    r_iss_age <= r_iss_age + CNT_W'(1);
                end
            end
            if (i_cmd.finish) begin
                r_min <= r_best;
                r_age <= r_best_age;
                if (r_last) begin
                    r_wp   <= '0;
                    r_seen <= '0;
                    r_min  <= '1;
                    r_age  <= '0;
                end
            end
            if (i_cmd.load_out) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Store, scan compare and result payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_mem[r_wp] <= i_hash_value;
            // The newest hash seeds the rescan; older entries replace it only when smaller.
            r_best     <= i_hash_value;
            r_best_age <= '0;
            r_rd_ptr   <= first_rd;
            if (!full && !fill_take) begin
                r_res <= r_min;
            end else begin
                r_res <= i_hash_value;
            end
        end
        if (i_cmd.scan && issue) begin
            r_rd_data <= r_mem[r_rd_ptr];
            r_rd_ptr  <= rd_dec;
            r_cmp_age <= r_iss_age;
        end
        if (i_cmd.scan && r_cmp_vld && (r_rd_data < r_best)) begin
            r_best     <= r_rd_data;
            r_best_age <= r_cmp_age;
        end
        if (i_cmd.finish) begin
            r_res <= r_best;
        end
        if (i_cmd.load_out) begin
            r_out_data <= r_res;
        end
    end

    assign o_out_valid   = r_out_vld;
    assign o_fingerprint = r_out_data;

    // A waiting result is never overwritten.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !i_out_ready) |-> !i_cmd.load_out)
        else $error("result register loaded while a result still waits");

    // A rescan only completes after its last compare.
    a_finish_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |-> (!issue && !r_cmp_vld))
        else $error("rescan finished with reads outstanding");

    // The write pointer stays inside the store.
    a_wp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.accept |=> (r_wp <= PTR_W'(WINDOW_MAX - 1)))
        else $error("write pointer left the store");

endmodule

`default_nettype wire

@@ sv/winnowing_fingerprint_selector.sv @@
// Winnowing fingerprint selector. Hashes arrive one per request on i_item; selected
// fingerprints leave on o_fp through an output register, so a new hash is taken while
// a result still waits. A hash that emits passes through the emit state, and a hash that
// finds the current minimum aged out of the window triggers a rescan of window_size - 1
// older entries through the store's single read port. The window size register (byte
// address 0, 7 bits, reset 4) is written over the APB-style port; the user must write it
// only while the block is idle, which the block itself does not enforce. Zero acts as one
// and values above WINDOW_MAX act as WINDOW_MAX. Store contents need no clearing.
`default_nettype none

module winnowing_fingerprint_selector #(
    parameter int WINDOW_MAX = 64,
    parameter int HASH_BITS  = 31
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    wfs_item_if.sink                           i_item,
    wfs_fp_if.source                           o_fp,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [wfs_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [wfs_pkg::APB_DW-1:0]    pwdata,
    output logic [wfs_pkg::APB_DW-1:0]         prdata,
    output logic                               pready
);

    logic [wfs_pkg::CFG_W-1:0] r_window_size;
    logic                      reg_hit;
    wfs_pkg::t_dp_cmd          cmd;
    wfs_pkg::t_dp_status       status;
    logic                      in_ready;
    logic                      out_valid;
    logic [HASH_BITS-1:0]      fingerprint;

    // Register decode.
    assign reg_hit = (paddr[wfs_pkg::PADDR_W-1:2] == wfs_pkg::REG_WINDOW_SIZE);
    assign pready  = 1'b1;

    // Window size register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_size <= wfs_pkg::WINDOW_SIZE_RESET;
        end else if (psel && penable && pwrite && reg_hit) begin
            r_window_size <= pwdata[wfs_pkg::CFG_W-1:0];
        end
    end

    // Read back.
    always_comb begin
        prdata = '0;
        if (reg_hit) begin
            prdata = {{(wfs_pkg::APB_DW - wfs_pkg::CFG_W){1'b0}}, r_window_size};
        end
    end

    wfs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_item.valid),
        .o_in_ready (in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    wfs_datapath #(
        .WINDOW_MAX (WINDOW_MAX),
        .HASH_BITS  (HASH_BITS)
    ) u_datapath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_status           (status),
        .i_hash_value       (i_item.hash_value),
        .i_last_of_document (i_item.last_of_document),
        .i_window_size      (r_window_size),
        .i_out_ready        (o_fp.ready),
        .o_out_valid        (out_valid),
        .o_fingerprint      (fingerprint)
    );

    // Channel connections.
    assign i_item.ready   = in_ready;
    assign o_fp.valid     = out_valid;
    assign o_fp.fingerprint = fingerprint;

endmodule

`default_nettype wire
